/* hdl/btci_pkg.sv */
// shared types and constants for the bias/temperature curve interpolator
package btci_pkg;

	// field widths
	localparam int CUR_W  = 23;
	localparam int MAG_W  = 24;
	localparam int IND_W  = 32;
	localparam int TEMP_W = 16;
	localparam int PROD_W = 56;
	localparam int CFG_W  = 32;

	// highest number of curves the temperature registers can describe
	localparam int TEMP_REGS = 4;

	// operation codes
	localparam logic [1:0] OP_APPEND = 2'd0;
	localparam logic [1:0] OP_QUERY  = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;
	localparam logic [1:0] OP_NONE   = 2'd3;

	// result status codes
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_BEYOND  = 2'd1;
	localparam logic [1:0] STAT_FULL    = 2'd2;
	localparam logic [1:0] STAT_NOMINAL = 2'd3;

	// configuration register indexes
	localparam logic [2:0] CFG_COUNT   = 3'd0;
	localparam logic [2:0] CFG_TEMP_A  = 3'd1;
	localparam logic [2:0] CFG_TEMP_B  = 3'd2;
	localparam logic [2:0] CFG_TEMP_C  = 3'd3;
	localparam logic [2:0] CFG_TEMP_D  = 3'd4;
	localparam logic [2:0] CFG_NOMINAL = 3'd5;

	// one stored curve point
	typedef struct packed {
		logic [CUR_W-1:0] cur;
		logic [IND_W-1:0] ind;
	} point_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEL,
		ST_RD,
		ST_CHK,
		ST_MUL,
		ST_DSTART,
		ST_DWAIT,
		ST_DONE
	} state_t;

endpackage

/* hdl/bias_temperature_curve_interpolator.sv */
// top level of the bias/temperature inductance curve interpolator
//
// Input words arrive on in_valid/in_stall, results leave on out_valid/out_stall;
// each input word yields exactly one result word. An append writes the point
// to the table in the accept cycle; append, clear and no-op words go from
// acceptance straight to the final state and from there into the output
// register. A query chooses curves, then scans points with a table read
// and a compare per point; each interpolation is a multiply followed by
// the 56-step serial divider, and a query runs at most three of them.
// One word is in work at a time. The next word is taken as soon as the
// result sits in the output register, even while the receiver stalls; a
// result that finds the output register still full waits in its final
// state until it drains. Reset clears the point counts, so all curves are
// empty, sets curve_count to one and zeroes the other registers; the point
// table itself is not cleared and needs no clearing pass. Configuration is
// written on cfg_we/cfg_index/cfg_data; the user must write it only while
// the block is idle, which the block itself does not enforce.
module bias_temperature_curve_interpolator #(
	parameter int CURVES = 4,
	parameter int POINTS_PER_CURVE = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [2:0]                            cfg_index,
	input  logic [btci_pkg::CFG_W-1:0]            cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [1:0]                            operation,
	input  logic [1:0]                            curve_index,
	input  logic [btci_pkg::CUR_W-1:0]            point_current,
	input  logic [btci_pkg::IND_W-1:0]            point_inductance,
	input  logic signed [btci_pkg::MAG_W-1:0]     bias_current,
	input  logic signed [btci_pkg::TEMP_W-1:0]    query_temperature,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [btci_pkg::IND_W-1:0]            inductance,
	output logic [1:0]                            status
);
	import btci_pkg::*;

	localparam int UMAX  = (CURVES < TEMP_REGS) ? CURVES : TEMP_REGS;
	localparam int DEPTH = UMAX * POINTS_PER_CURVE;
	localparam int AW    = $clog2(DEPTH);
	localparam int KW    = $clog2(POINTS_PER_CURVE + 1);

	// state and registers
	state_t state_q, state_nx;

	logic [2:0]               cc_q;
	logic signed [TEMP_W-1:0] ctemp_q [TEMP_REGS];
	logic [IND_W-1:0]         nom_q;
	logic [KW-1:0]            cnt_q [TEMP_REGS];

	logic [MAG_W-1:0]         cur_q;
	logic signed [TEMP_W-1:0] qt_q;
	logic [IND_W-1:0]         res_ind_q;
	logic [1:0]               res_st_q;
	logic                     out_valid_q;
	logic [IND_W-1:0]         out_ind_q;
	logic [1:0]               out_st_q;

	logic                     two_q;
	logic                     pass_q;
	logic [1:0]               cb_q;
	logic signed [TEMP_W-1:0] tl_q;
	logic signed [TEMP_W-1:0] th_q;

	logic [AW-1:0]            addr_q;
	logic [KW-1:0]            k_q;
	logic [KW-1:0]            n_q;
	logic [CUR_W-1:0]         pcur_q;
	logic [IND_W-1:0]         pind_q;

	logic signed [IND_W:0]    base_q;
	logic signed [IND_W:0]    vl_q;
	logic                     neg_q;
	logic [IND_W-1:0]         mag_q;
	logic [MAG_W-1:0]         mb_q;
	logic [MAG_W-1:0]         den_q;
	logic [PROD_W-1:0]        prod_q;
	logic                     kind_q;

	// handshake and control
	logic accept, out_free, out_load, ram_re, div_start, div_done;
	logic app_full, ram_we;
	logic [AW-1:0] waddr;
	point_t wdata, rd;
	logic [PROD_W-1:0] div_quo;
	logic [MAG_W-1:0] mag_in;

	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// bias magnitude; the most negative code maps onto 2^23
	assign mag_in = bias_current[MAG_W-1] ? (~bias_current + 1'b1) : bias_current;

	// append bookkeeping
	assign app_full = (int'(curve_index) >= CURVES) ||
		(cnt_q[curve_index] >= KW'(POINTS_PER_CURVE));
	assign ram_we   = accept && (operation == OP_APPEND) && !app_full;
	assign waddr    = AW'(curve_index) * AW'(POINTS_PER_CURVE) + AW'(cnt_q[curve_index]);
	assign wdata    = '{cur: point_current, ind: point_inductance};

	btci_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (ram_re),
		.raddr (addr_q),
		.rdata (rd)
	);

	btci_div #(.NUM_W(PROD_W), .DEN_W(MAG_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (prod_q),
		.den    (den_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	// curve selection across temperatures
	logic [2:0]               used;
	logic [2:0]               na;
	logic [1:0]               act [TEMP_REGS];
	logic [1:0]               kk;
	logic                     stop;
	logic                     sel_none, sel_two;
	logic [1:0]               sel_a, sel_b;
	logic signed [TEMP_W-1:0] tf, tlast, sel_tl, sel_th;

	always_comb begin
		if (cc_q == 3'd0) begin
			used = 3'd1;
		end else if (cc_q > 3'(UMAX)) begin
			used = 3'(UMAX);
		end else begin
			used = cc_q;
		end
		na = '0;
		for (int c = 0; c < TEMP_REGS; c++) begin
			act[c] = '0;
		end
		for (int c = 0; c < TEMP_REGS; c++) begin
			if (3'(c) < used && cnt_q[c] != '0) begin
				act[na[1:0]] = 2'(c);
				na = na + 3'd1;
			end
		end
		tf    = ctemp_q[act[0]];
		tlast = ctemp_q[act[2'(na - 3'd1)]];
		kk    = 2'd1;
		stop  = 1'b0;
		for (int j = 0; j < 2; j++) begin
			if (!stop) begin
				if ((3'(kk) < na - 3'd1) && (ctemp_q[act[kk]] < qt_q)) begin
					kk = kk + 2'd1;
				end else begin
					stop = 1'b1;
				end
			end
		end
		sel_none = (na == 3'd0);
		sel_two  = 1'b0;
		sel_a    = act[0];
		sel_b    = act[kk];
		sel_tl   = ctemp_q[act[2'(kk - 2'd1)]];
		sel_th   = ctemp_q[act[kk]];
		if (na == 3'd1 || qt_q <= tf) begin
			sel_a = act[0];
		end else if (qt_q >= tlast) begin
			sel_a = act[2'(na - 3'd1)];
		end else if (sel_th == qt_q) begin
			sel_a = act[kk];
		end else begin
			sel_a   = act[2'(kk - 2'd1)];
			sel_two = 1'b1;
		end
	end

	// point compare and value of the finished curve
	logic              hit, last, curve_done;
	logic signed [IND_W:0] sq, fin, curve_val, cdiff, tdiff;

	always_comb begin
		hit   = {1'b0, rd.cur} >= cur_q;
		last  = (k_q + KW'(1)) == n_q;
		sq    = neg_q ? -$signed({1'b0, div_quo[IND_W-1:0]})
			: $signed({1'b0, div_quo[IND_W-1:0]});
		fin   = base_q + sq;
		curve_val = (state_q == ST_CHK) ? $signed({1'b0, rd.ind}) : fin;
		curve_done = (state_q == ST_CHK && hit && k_q == '0) ||
			(state_q == ST_DWAIT && div_done && !kind_q);
		cdiff = $signed({1'b0, rd.ind}) - $signed({1'b0, pind_q});
		tdiff = curve_val - vl_q;
	end

	// next state
	state_t cd_next;
	always_comb begin
		if (!pass_q && two_q) begin
			cd_next = ST_RD;
		end else if (pass_q) begin
			cd_next = ST_MUL;
		end else begin
			cd_next = ST_DONE;
		end
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_nx = (operation == OP_QUERY) ? ST_SEL : ST_DONE;
				end
			end
			ST_SEL: state_nx = sel_none ? ST_DONE : ST_RD;
			ST_RD: state_nx = ST_CHK;
			ST_CHK: begin
				if (hit) begin
					state_nx = (k_q == '0) ? cd_next : ST_MUL;
				end else begin
					state_nx = last ? ST_DONE : ST_RD;
				end
			end
			ST_MUL: state_nx = ST_DSTART;
			ST_DSTART: state_nx = ST_DWAIT;
			ST_DWAIT: begin
				if (div_done) begin
					state_nx = kind_q ? ST_DONE : cd_next;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		ram_re    = (state_q == ST_RD);
		div_start = (state_q == ST_DSTART);
		out_load  = (state_q == ST_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q  <= 3'd1;
			nom_q <= '0;
			for (int i = 0; i < TEMP_REGS; i++) begin
				ctemp_q[i] <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_COUNT:   cc_q <= cfg_data[2:0];
				CFG_TEMP_A:  ctemp_q[0] <= cfg_data[TEMP_W-1:0];
				CFG_TEMP_B:  ctemp_q[1] <= cfg_data[TEMP_W-1:0];
				CFG_TEMP_C:  ctemp_q[2] <= cfg_data[TEMP_W-1:0];
				CFG_TEMP_D:  ctemp_q[3] <= cfg_data[TEMP_W-1:0];
				CFG_NOMINAL: nom_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// per-curve point counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TEMP_REGS; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (accept && operation == OP_CLEAR) begin
			for (int i = 0; i < TEMP_REGS; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (ram_we) begin
			cnt_q[curve_index] <= cnt_q[curve_index] + KW'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_ind_q <= res_ind_q;
			out_st_q  <= res_st_q;
		end
	end

	// query datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				cur_q     <= mag_in;
				qt_q      <= query_temperature;
				res_ind_q <= '0;
				res_st_q  <= (operation == OP_APPEND && app_full) ? STAT_FULL : STAT_OK;
				pass_q    <= 1'b0;
			end
			ST_SEL: begin
				two_q  <= sel_two;
				cb_q   <= sel_b;
				tl_q   <= sel_tl;
				th_q   <= sel_th;
				addr_q <= AW'(sel_a) * AW'(POINTS_PER_CURVE);
				k_q    <= '0;
				n_q    <= cnt_q[sel_a];
				if (sel_none) begin
					res_ind_q <= nom_q;
					res_st_q  <= STAT_NOMINAL;
				end
			end
			ST_CHK: begin
				if (hit && k_q != '0) begin
					// interpolate along the curve
					base_q <= $signed({1'b0, pind_q});
					neg_q  <= cdiff[IND_W];
					mag_q  <= cdiff[IND_W] ? IND_W'(-cdiff) : cdiff[IND_W-1:0];
					mb_q   <= cur_q - {1'b0, pcur_q};
					den_q  <= {1'b0, rd.cur} - {1'b0, pcur_q};
					kind_q <= 1'b0;
				end else if (!hit) begin
					pcur_q <= rd.cur;
					pind_q <= rd.ind;
					addr_q <= addr_q + AW'(1);
					k_q    <= k_q + KW'(1);
					if (last) begin
						res_ind_q <= '0;
						res_st_q  <= STAT_BEYOND;
					end
				end
			end
			ST_MUL: prod_q <= mag_q * mb_q;
			ST_DWAIT: begin
				if (div_done && kind_q) begin
					res_ind_q <= fin[IND_W-1:0];
					res_st_q  <= STAT_OK;
				end
			end
			default: ;
		endcase

		// a curve has produced its value
		if (curve_done) begin
			if (!pass_q && two_q) begin
				vl_q   <= curve_val;
				pass_q <= 1'b1;
				addr_q <= AW'(cb_q) * AW'(POINTS_PER_CURVE);
				k_q    <= '0;
				n_q    <= cnt_q[cb_q];
			end else if (pass_q) begin
				// interpolate across temperature
				base_q <= vl_q;
				neg_q  <= tdiff[IND_W];
				mag_q  <= tdiff[IND_W] ? IND_W'(-tdiff) : tdiff[IND_W-1:0];
				mb_q   <= MAG_W'($signed({qt_q[TEMP_W-1], qt_q}) -
					$signed({tl_q[TEMP_W-1], tl_q}));
				den_q  <= MAG_W'($signed({th_q[TEMP_W-1], th_q}) -
					$signed({tl_q[TEMP_W-1], tl_q}));
				kind_q <= 1'b1;
			end else begin
				res_ind_q <= curve_val[IND_W-1:0];
				res_st_q  <= STAT_OK;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign inductance = out_ind_q;
	assign status     = out_st_q;

	// checks
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != ST_IDLE)
		else $error("accepted word left the sequencer idle");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CHK |-> k_q < n_q)
		else $error("point scan ran past the curve");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STAT_BEYOND || status == STAT_FULL) |-> inductance == '0)
		else $error("failed result carries an inductance");

	a_div_only_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DWAIT)
		else $error("divider finished outside its wait state");

endmodule

/* hdl/btci_ram.sv */
// point table memory, one write port and one registered read port
module btci_ram #(
	parameter int DEPTH = 64,
	parameter int AW = 6
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  btci_pkg::point_t      wdata,
	input  logic                  re,
	input  logic [AW-1:0]         raddr,
	output btci_pkg::point_t      rdata
);
	import btci_pkg::*;

	point_t mem [DEPTH];
	point_t rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* hdl/btci_div.sv */
// restoring unsigned divider, one quotient bit per cycle
module btci_div #(
	parameter int NUM_W = 56,
	parameter int DEN_W = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);
	localparam int CW = $clog2(NUM_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   rem_sh;
	logic [DEN_W:0]   rem_sub;
	logic             ge;

	// one trial subtraction
	always_comb begin
		rem_sh  = {rem_q, quo_q[NUM_W-1]};
		ge      = rem_sh >= {1'b0, den_q};
		rem_sub = rem_sh - {1'b0, den_q};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule
